[rtl/hrhp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared constants, types and the hex digit decode for the record parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned ACC_W    = 12;
  localparam int unsigned INDEX_W  = 7;

  localparam logic [ADDR_W-1:0] FLASH_BASE_RESET = 32'h0800_0000;
  localparam logic [POS_W-1:0]  POS_MAX          = 10'd1023;
  localparam logic [POS_W-1:0]  POS_COUNT_END    = 10'd2;
  localparam logic [POS_W-1:0]  POS_OFFSET_END   = 10'd6;
  localparam logic [POS_W-1:0]  POS_ADDR_PAD     = 10'd7;
  localparam logic [POS_W-1:0]  POS_TYPE         = 10'd8;
  localparam logic [POS_W-1:0]  DATA_START       = 10'd9;

  localparam logic [CHAR_W-1:0] CHAR_COLON     = 8'h3A;  // ':'
  localparam logic [CHAR_W-1:0] CHAR_SKIP_TYPE = 8'h34;  // '4'
  localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE      = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F   = 8'h46;  // 'F'
  localparam logic [CHAR_W-1:0] ALPHA_BIAS     = 8'd55;

  // one decoded halfword write, valid when emit is set
  typedef struct packed {
    logic              emit;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              last_of_record;
  } result_t;

  // 0-9 and A-F decode, anything else reads as zero
  function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    begin
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        diff = c - CHAR_ZERO;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
        diff = c - ALPHA_BIAS;
      end
      hex_digit = diff[3:0];
    end
  endfunction

endpackage

[rtl/hrhp_char_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_char_if
// character stream channel, one ascii character per word
// ----------------------------------------------------------------------------
interface hrhp_char_if;
  logic                         valid;
  logic                         ready;
  logic [hrhp_pkg::CHAR_W-1:0]  ascii_char;

  modport source (output valid, output ascii_char, input ready);
  modport sink   (input valid, input ascii_char, output ready);
endinterface

[rtl/hrhp_write_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_write_if
// halfword write channel, one address/data pair per word
// ----------------------------------------------------------------------------
interface hrhp_write_if;
  logic                         valid;
  logic                         ready;
  logic [hrhp_pkg::ADDR_W-1:0]  write_address;
  logic [hrhp_pkg::DATA_W-1:0]  write_data;
  logic                         last_of_record;

  modport source (output valid, output write_address, output write_data,
                  output last_of_record, input ready);
  modport sink   (input valid, input write_address, input write_data,
                  input last_of_record, output ready);
endinterface

[rtl/hex_record_halfword_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_halfword_parser
// streaming hex record decoder, characters in, halfword flash writes out
// ----------------------------------------------------------------------------
// chars: one ascii character per word, valid/ready. a ':' opens a record;
//   count, offset and type digits follow, then data digits, four per
//   halfword. records of type '4' are dropped whole.
// writes: one halfword per word with its flash address (flash_base | offset
//   plus twice the halfword index) and a last-of-record flag.
// cfg_we/cfg_wdata: writes flash_base; change it only while idle.
// output: a halfword appears on writes the cycle after its fourth data
//   character is taken. throughput is one character per cycle unless
//   writes stall; the decode step is a single pass through the record
//   state registers; the 32-bit address add precedes the output register.
// stall: the output register holds a word until writes.ready; chars.ready
//   stays high while the output register is empty or being drained, so a
//   character is only held back when a word is waiting and the receiver
//   stalls.
// reset: rst (synchronous) clears the record state and the output valid,
//   and loads flash_base with 0x0800_0000. nothing needs clearing after.
// ----------------------------------------------------------------------------
module hex_record_halfword_parser (
  input  logic                          clk,
  input  logic                          rst,
  hrhp_char_if.sink                     chars,
  hrhp_write_if.source                  writes,
  input  logic                          cfg_we,
  input  logic [hrhp_pkg::ADDR_W-1:0]   cfg_wdata
);

  logic [hrhp_pkg::ADDR_W-1:0] flash_base;
  hrhp_pkg::result_t           result;
  logic                        char_fire;
  logic                        out_valid, out_valid_next;
  logic [hrhp_pkg::ADDR_W-1:0] out_address;
  logic [hrhp_pkg::DATA_W-1:0] out_data;
  logic                        out_last;

  // base address register
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base <= hrhp_pkg::FLASH_BASE_RESET;
    end else if (cfg_we) begin
      flash_base <= cfg_wdata;
    end
  end

  // take a character unless a finished word is stuck in the output register
  assign chars.ready = !out_valid || writes.ready;
  assign char_fire   = chars.valid && chars.ready;

  hrhp_record_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .step       (char_fire),
    .ascii_char (chars.ascii_char),
    .flash_base (flash_base),
    .result     (result)
  );

  // output register: loads on an emitting character, clears when drained
  always_comb begin
    if (char_fire) begin
      out_valid_next = result.emit;
    end else begin
      out_valid_next = out_valid && !writes.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // payload needs no reset, only loaded with a fresh word
  always_ff @(posedge clk) begin
    if (char_fire && result.emit) begin
      out_address <= result.write_address;
      out_data    <= result.write_data;
      out_last    <= result.last_of_record;
    end
  end

  assign writes.valid          = out_valid;
  assign writes.write_address  = out_address;
  assign writes.write_data     = out_data;
  assign writes.last_of_record = out_last;

endmodule

[rtl/hrhp_record_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_record_decoder
// per-record state and the one-character decode step
// ----------------------------------------------------------------------------
module hrhp_record_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [hrhp_pkg::CHAR_W-1:0]   ascii_char,
  input  logic [hrhp_pkg::ADDR_W-1:0]   flash_base,
  output hrhp_pkg::result_t             result
);

  logic [hrhp_pkg::POS_W-1:0]    char_position, char_position_next;
  logic                          in_record, in_record_next;
  logic [hrhp_pkg::COUNT_W-1:0]  byte_count, byte_count_next;
  logic [hrhp_pkg::OFFSET_W-1:0] record_offset, record_offset_next;
  logic [hrhp_pkg::ACC_W-1:0]    nibble_acc, nibble_acc_next;
  logic [hrhp_pkg::INDEX_W-1:0]  halfword_index, halfword_index_next;

  logic [3:0]                    digit;
  logic [hrhp_pkg::POS_W-1:0]    pos;
  logic [hrhp_pkg::POS_W-1:0]    data_pos;
  logic [hrhp_pkg::ADDR_W-1:0]   base_addr;
  logic [hrhp_pkg::INDEX_W:0]    index_plus;
  logic                          last;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= '0;
      in_record      <= 1'b0;
      byte_count     <= '0;
      record_offset  <= '0;
      nibble_acc     <= '0;
      halfword_index <= '0;
    end else if (step) begin
      char_position  <= char_position_next;
      in_record      <= in_record_next;
      byte_count     <= byte_count_next;
      record_offset  <= record_offset_next;
      nibble_acc     <= nibble_acc_next;
      halfword_index <= halfword_index_next;
    end
  end

  always_comb begin
    digit      = hrhp_pkg::hex_digit(ascii_char);
    pos        = (char_position == hrhp_pkg::POS_MAX) ? char_position
                                                      : char_position + 1'b1;
    data_pos   = pos - hrhp_pkg::DATA_START;
    base_addr  = flash_base | {{(hrhp_pkg::ADDR_W-hrhp_pkg::OFFSET_W){1'b0}},
                               record_offset};
    index_plus = {1'b0, halfword_index} + 1'b1;
    last       = index_plus >= {1'b0, byte_count[hrhp_pkg::COUNT_W-1:1]};

    result.emit           = 1'b0;
    result.write_address  = base_addr
                          + {{(hrhp_pkg::ADDR_W-hrhp_pkg::INDEX_W-1){1'b0}},
                             halfword_index, 1'b0};
    // first record byte lands in the low byte
    result.write_data     = {nibble_acc[3:0], digit, nibble_acc[11:8],
                             nibble_acc[7:4]};
    result.last_of_record = last;

    char_position_next  = char_position;
    in_record_next      = in_record;
    byte_count_next     = byte_count;
    record_offset_next  = record_offset;
    nibble_acc_next     = nibble_acc;
    halfword_index_next = halfword_index;

    if (ascii_char == hrhp_pkg::CHAR_COLON) begin
      char_position_next  = '0;
      in_record_next      = 1'b1;
      byte_count_next     = '0;
      record_offset_next  = '0;
      nibble_acc_next     = '0;
      halfword_index_next = '0;
    end else if (in_record) begin
      char_position_next = pos;
      priority if (pos <= hrhp_pkg::POS_COUNT_END) begin
        byte_count_next = {byte_count[3:0], digit};
      end else if (pos <= hrhp_pkg::POS_OFFSET_END) begin
        record_offset_next = {record_offset[11:0], digit};
      end else if (pos == hrhp_pkg::POS_ADDR_PAD) begin
        char_position_next = pos;
      end else if (pos == hrhp_pkg::POS_TYPE) begin
        // skip type or a count under two bytes ends the record here
        if (ascii_char == hrhp_pkg::CHAR_SKIP_TYPE ||
            byte_count[hrhp_pkg::COUNT_W-1:1] == '0) begin
          in_record_next = 1'b0;
        end
      end else if (data_pos[1:0] != 2'd3) begin
        nibble_acc_next = {nibble_acc[7:0], digit};
      end else begin
        result.emit         = 1'b1;
        nibble_acc_next     = '0;
        halfword_index_next = index_plus[hrhp_pkg::INDEX_W-1:0];
        if (last) begin
          in_record_next = 1'b0;
        end
      end
    end
  end

endmodule

[rtl/hrhp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_checker
// port-level checks for the hex record parser, bound to the top level
// ----------------------------------------------------------------------------
module hrhp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [hrhp_pkg::ADDR_W-1:0]   out_address,
  input  logic [hrhp_pkg::DATA_W-1:0]   out_data,
  input  logic                          out_last
);

  // a stalled word stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_address) &&
                                $stable(out_data) && $stable(out_last))
    else $error("stalled write word changed or dropped");

  // no word out of reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("write word valid right after reset");

  // empty output register never holds back characters
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("char channel stalled with output empty");

  // a fresh word follows an accepted character
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !($past(out_valid) && !$past(out_ready)) |->
      $past(in_valid && in_ready))
    else $error("write word appeared without a character");

endmodule

bind hex_record_halfword_parser hrhp_checker u_hrhp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chars.valid),
  .in_ready    (chars.ready),
  .out_valid   (writes.valid),
  .out_ready   (writes.ready),
  .out_address (writes.write_address),
  .out_data    (writes.write_data),
  .out_last    (writes.last_of_record)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for hex_record_halfword_parser
// ----------------------------------------------------------------------------
// a character stream of hex records is driven into the parser under random
// idling on both sides. each accepted character also goes through a local
// record decoder, which queues the halfword writes the parser should make.
// every write word leaving the parser is checked field by field against the
// oldest queued write. flash_base is reloaded between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  import hrhp_pkg::*;

  // one halfword write as the parser should present it
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } halfword_write_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  hrhp_char_if  chars_if ();
  hrhp_write_if writes_if ();

  hex_record_halfword_parser dut (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars_if),
    .writes    (writes_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // local copy of the record decoder state
  logic [ADDR_W-1:0]   flash_base_model = FLASH_BASE_RESET;
  logic [POS_W-1:0]    rec_pos          = '0;
  logic                rec_open         = 1'b0;
  logic [COUNT_W-1:0]  rec_count        = '0;
  logic [OFFSET_W-1:0] rec_offset       = '0;
  logic [ACC_W-1:0]    nib_acc          = '0;
  logic [INDEX_W-1:0]  hw_index         = '0;

  halfword_write_t   pending_writes[$];  // writes still owed by the parser
  logic [CHAR_W-1:0] char_backlog[$];    // characters not yet taken
  logic [CHAR_W-1:0] record_text[$];     // record being assembled
  int unsigned       stream_chars  = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       src_idle_pct  = 20;
  int unsigned       sink_idle_pct = 84;
  logic              sender_hold   = 1'b0;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // record decoder used for prediction
  // ---------------------------------------------------------------------------

  // 0-9 and A-F only, every other character reads as zero
  function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      v = c - CHAR_UPPER_A + 8'd10;
    end
    return v[3:0];
  endfunction

  // advance the decoder by one taken character, queue any write it causes
  task automatic decode_char(input logic [CHAR_W-1:0] c);
    logic [3:0]       d;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] rel;
    halfword_write_t  w;
    d = digit_value(c);
    if (c == CHAR_COLON) begin
      // a colon always opens a fresh record, even inside one
      rec_pos    = '0;
      rec_open   = 1'b1;
      rec_count  = '0;
      rec_offset = '0;
      nib_acc    = '0;
      hw_index   = '0;
    end else if (rec_open) begin
      if (rec_pos != POS_MAX) begin
        rec_pos = rec_pos + 1'b1;
      end
      p = rec_pos;
      if (p <= POS_COUNT_END) begin
        rec_count = {rec_count[3:0], d};
      end else if (p <= POS_OFFSET_END) begin
        rec_offset = {rec_offset[11:0], d};
      end else if (p == POS_TYPE) begin
        // type '4' drops the record, a count below two has nothing to write
        if (c == CHAR_SKIP_TYPE || rec_count[7:1] == 7'd0) begin
          rec_open = 1'b0;
        end
      end else if (p >= DATA_START) begin
        rel = p - DATA_START;
        if (rel[1:0] != 2'd3) begin
          nib_acc = {nib_acc[7:0], d};
        end else begin
          // digits d0 d1 d2 d3: first byte d0d1 lands in the low byte
          w.data = {nib_acc[3:0], d, nib_acc[11:8], nib_acc[7:4]};
          w.addr = (flash_base_model | {16'h0000, rec_offset})
                 + {24'h00_0000, hw_index, 1'b0};
          w.last = (({1'b0, hw_index} + 8'd1) >= {1'b0, rec_count[7:1]});
          pending_writes.push_back(w);
          nib_acc  = '0;
          hw_index = hw_index + 1'b1;
          if (w.last) begin
            rec_open = 1'b0;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // character driver: offers the backlog head, holds it until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid      <= 1'b0;
      chars_if.ascii_char <= '0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        decode_char(chars_if.ascii_char);
        void'(char_backlog.pop_front());
      end
      // a word offered and not yet taken stays on the bus untouched
      if (!chars_if.valid || chars_if.ready) begin
        if (char_backlog.size() != 0 && !sender_hold &&
            $urandom_range(99) >= src_idle_pct) begin
          chars_if.valid      <= 1'b1;
          chars_if.ascii_char <= char_backlog[0];
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // write monitor: random ready, compares each taken word with the oldest
  // queued write
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : write_monitor
    halfword_write_t want;
    if (rst) begin
      writes_if.ready <= 1'b0;
    end else begin
      if (writes_if.valid && writes_if.ready) begin
        if (pending_writes.size() == 0) begin
          mismatch_count++;
          $display("%0t: write expected none actual addr=%h data=%h last=%b",
                   $realtime, writes_if.write_address, writes_if.write_data,
                   writes_if.last_of_record);
        end else begin
          want = pending_writes.pop_front();
          if (writes_if.write_address !== want.addr) begin
            mismatch_count++;
            $display("%0t: write_address expected %h actual %h", $realtime,
                     want.addr, writes_if.write_address);
          end
          if (writes_if.write_data !== want.data) begin
            mismatch_count++;
            $display("%0t: write_data expected %h actual %h", $realtime,
                     want.data, writes_if.write_data);
          end
          if (writes_if.last_of_record !== want.last) begin
            mismatch_count++;
            $display("%0t: last_of_record expected %b actual %b", $realtime,
                     want.last, writes_if.last_of_record);
          end
        end
      end
      writes_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return CHAR_ZERO + {4'h0, v};
    end
    return CHAR_UPPER_A + {4'h0, v} - 8'd10;
  endfunction

  task automatic queue_char(input logic [CHAR_W-1:0] c);
    char_backlog.push_back(c);
    stream_chars++;
  endtask

  // nd upper-case hex digits of v, most significant first
  task automatic append_hex(input logic [15:0] v, input int nd);
    int i;
    for (i = nd - 1; i >= 0; i--) begin
      record_text.push_back(hex_char(4'(v >> (4 * i))));
    end
  endtask

  // one record: mostly well formed, with some bad digits, some skipped
  // types and some cut short; forced_count below zero picks a random count
  task automatic add_record(input int forced_count);
    int unsigned n_bytes;
    int unsigned pick;
    int unsigned keep;
    int unsigned i;
    record_text.delete();
    pick = $urandom_range(99);
    if (forced_count >= 0) begin
      n_bytes = forced_count;
    end else if (pick < 8) begin
      n_bytes = $urandom_range(40, 13);
    end else begin
      n_bytes = $urandom_range(12, 0);
    end
    record_text.push_back(CHAR_COLON);
    append_hex(16'(n_bytes), 2);
    append_hex(16'($urandom()), 4);
    record_text.push_back(hex_char(4'($urandom_range(15))));
    // type digit: skip marker, ordinary types or any byte at all
    pick = $urandom_range(99);
    if (forced_count < 0 && pick < 25) begin
      record_text.push_back(CHAR_SKIP_TYPE);
    end else if (pick < 88) begin
      record_text.push_back(hex_char(4'($urandom_range(3))));
    end else begin
      record_text.push_back(8'($urandom_range(255)));
    end
    for (i = 0; i < 2 * n_bytes; i++) begin
      if ($urandom_range(99) < 6) begin
        record_text.push_back(8'($urandom_range(255)));
      end else begin
        record_text.push_back(hex_char(4'($urandom_range(15))));
      end
    end
    append_hex(16'($urandom_range(255)), 2);
    record_text.push_back(8'h0D);
    record_text.push_back(8'h0A);
    keep = record_text.size();
    if (forced_count < 0 && $urandom_range(99) < 8) begin
      keep = $urandom_range(record_text.size(), 1);
    end
    for (i = 0; i < keep; i++) begin
      queue_char(record_text[i]);
    end
  endtask

  // wait until all characters are taken and all writes have come out
  task automatic settle();
    do @(negedge clk);
    while (char_backlog.size() != 0 || pending_writes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_flash_base(input logic [ADDR_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    flash_base_model = v;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    string       directed_text;
    int          phase;
    int unsigned phase_start;
    int unsigned i;
    logic        paused;
    logic [ADDR_W-1:0] base_value;

    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme bytes outside a record, a colon restart, one
    // halfword with a lower-case digit at offset FFFF, then a skipped record
    @(negedge clk);
    queue_char(8'h00);
    queue_char(8'hFF);
    directed_text = ":1:02FFFF00Fe01:01000004";
    for (i = 0; i < directed_text.len(); i++) begin
      queue_char(directed_text[i]);
    end

    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0, 1: begin
          src_idle_pct  = 20;
          sink_idle_pct = 84;
        end
        2, 3: begin
          src_idle_pct  = 84;
          sink_idle_pct = 20;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      case (phase)
        0:       base_value = 32'hFFFF_FFFF;
        1:       base_value = 32'h0000_0000;
        3:       base_value = 32'hFFFF_0000;
        5:       base_value = FLASH_BASE_RESET;
        default: base_value = $urandom();
      endcase
      load_flash_base(base_value);

      @(negedge clk);
      phase_start = stream_chars;
      paused      = 1'b0;
      // the longest record, once, with the register back at its reset value
      if (phase == 5) begin
        add_record(255);
      end
      while (stream_chars - phase_start < 90) begin
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(4, 1)) queue_char(8'($urandom_range(255)));
        end else begin
          add_record(-1);
        end
        // midway through phase 1 the sender stops until the parser drains
        if (phase == 1 && !paused && stream_chars - phase_start >= 45) begin
          paused = 1'b1;
          do @(negedge clk);
          while (char_backlog.size() > 8);
          sender_hold = 1'b1;
          do @(negedge clk);
          while (chars_if.valid || pending_writes.size() != 0);
          repeat (3) @(negedge clk);
          sender_hold = 1'b0;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
